// ===== src/mrq_pkg.sv =====
// mrq_pkg: word types, operation and status codes for the mailbox ring queue
// no dependencies; used by every module under src

package mrq_pkg;

   // fixed sizes of the ring and its words
   localparam int unsigned DEPTH     = 16;
   localparam int unsigned MSG_WIDTH = 32;
   localparam int unsigned IDX_W     = $clog2(DEPTH);
   localparam int unsigned LVL_W     = 5;
   localparam int unsigned CAP_W     = 5;

   // reset value of the capacity register
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   // operation codes
   localparam logic [1:0] OP_GET       = 2'd0;
   localparam logic [1:0] OP_PUT_BACK  = 2'd1;
   localparam logic [1:0] OP_PUT_FRONT = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           op;
      logic [MSG_WIDTH-1:0] msg_in;
      logic                 waiter_present;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [MSG_WIDTH-1:0] msg_out;
      logic                 handed_over;
      logic [LVL_W-1:0]     level;
   } rsp_type;

endpackage

// ===== src/mrq_in_stage.sv =====
// mrq_in_stage: input register of the mailbox ring queue
// depends on mrq_pkg

module mrq_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrq_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output mrq_pkg::req_type item
);

   logic             valid_ff;
   logic             valid_in;
   mrq_pkg::req_type item_ff;
   logic             accept;

   // free when empty or when the held word moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/mrq_exec.sv =====
// mrq_exec: ring storage, pointers, count and the per-operation logic
// depends on mrq_pkg

module mrq_exec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mrq_pkg::CAP_W-1:0]   capacity,
   input  mrq_pkg::req_type            item,
   input  logic                        advance,
   output mrq_pkg::rsp_type            result
);

   localparam int unsigned IW = mrq_pkg::IDX_W;
   localparam int unsigned LW = mrq_pkg::LVL_W;
   localparam int unsigned CW = mrq_pkg::CAP_W;

   logic [IW-1:0]                   rd_ff, rd_in;
   logic [IW-1:0]                   wr_ff, wr_in;
   logic [LW-1:0]                   count_ff, count_in;
   logic [mrq_pkg::MSG_WIDTH-1:0]   ring_ff [mrq_pkg::DEPTH];

   logic [CW-1:0]                   cap;
   logic [CW-1:0]                   rd_step, wr_step;
   logic [IW-1:0]                   rd_back;
   logic                            ring_we;
   logic [IW-1:0]                   ring_addr;

   // capacity saturates into 1..DEPTH
   always_comb begin
      if (capacity == '0) begin
         cap = CW'(1);
      end else if (capacity > CW'(mrq_pkg::DEPTH)) begin
         cap = CW'(mrq_pkg::DEPTH);
      end else begin
         cap = capacity;
      end
   end

   // forward steps wrap at or beyond capacity, backward step wraps to capacity - 1
   always_comb begin
      rd_step = CW'(rd_ff) + CW'(1);
      if (rd_step >= cap) begin
         rd_step = '0;
      end
      wr_step = CW'(wr_ff) + CW'(1);
      if (wr_step >= cap) begin
         wr_step = '0;
      end
      rd_back = (rd_ff == '0) ? IW'(cap - CW'(1)) : rd_ff - IW'(1);
   end

   // operation decode and next state
   always_comb begin
      rd_in              = rd_ff;
      wr_in              = wr_ff;
      count_in           = count_ff;
      ring_we            = 1'b0;
      ring_addr          = wr_ff;
      result.status      = mrq_pkg::ST_OK;
      result.msg_out     = '0;
      result.handed_over = 1'b0;
      case (item.op)
         mrq_pkg::OP_GET: begin
            if (count_ff != '0) begin
               count_in       = count_ff - LW'(1);
               result.msg_out = ring_ff[rd_ff];
               rd_in          = IW'(rd_step);
            end else begin
               result.status = mrq_pkg::ST_EMPTY;
            end
         end
         mrq_pkg::OP_CLEAR: begin
            if (!item.waiter_present) begin
               count_in = '0;
               rd_in    = '0;
               wr_in    = '0;
            end
         end
         default: begin
            if (item.waiter_present) begin
               result.msg_out     = item.msg_in;
               result.handed_over = 1'b1;
            end else if (count_ff >= LW'(cap)) begin
               result.status = mrq_pkg::ST_FULL;
            end else begin
               ring_we  = 1'b1;
               count_in = count_ff + LW'(1);
               if (item.op == mrq_pkg::OP_PUT_FRONT) begin
                  rd_in     = rd_back;
                  ring_addr = rd_back;
               end else begin
                  ring_addr = wr_ff;
                  wr_in     = IW'(wr_step);
               end
            end
         end
      endcase
      result.level = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else if (advance) begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   // ring words, no reset
   always_ff @(posedge clock) begin
      if (advance && ring_we) begin
         ring_ff[ring_addr] <= item.msg_in;
      end
   end

endmodule

// ===== src/mrq_out_stage.sv =====
// mrq_out_stage: result register and the advance decision for the pipeline
// depends on mrq_pkg

module mrq_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  mrq_pkg::rsp_type result,
   output logic             advance,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrq_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   mrq_pkg::rsp_type data_ff;

   // a word moves in when the register is empty or being drained
   assign advance = item_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/mailbox_ring_queue.sv =====
// mailbox_ring_queue: top level of the mailbox ring queue
// depends on mrq_pkg, mrq_in_stage, mrq_exec, mrq_out_stage
//
// Usage:
//   req_*  : one operation word per handshake (get, put at back, put at front,
//            clear) with the message and the waiter flag.
//   rsp_*  : one result word per operation: status, popped or handed-over
//            message, handed-over flag and the ring level afterwards.
//   csr_*  : capacity register write; always ready. It is to be written only
//            while idle; the block itself does not enforce this.
// Words pass from the input register via mrq_exec to the result register.
// Throughput: one operation per cycle unless the receiver stalls; the input
//   and result registers each hold one word and advance in the same cycle.
// Reset clears pointers, level and both valid flags and sets capacity to 16.
//   Ring words are not cleared; only written entries are ever read.
// When the receiver stalls, the result register holds and the input register
//   still takes one more word, after which req_ready drops.

module mailbox_ring_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mrq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mrq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mrq_pkg::CAP_W-1:0] csr_data
);

   logic [mrq_pkg::CAP_W-1:0] capacity_ff;
   logic                      item_valid;
   mrq_pkg::req_type          item;
   mrq_pkg::rsp_type          result;
   logic                      advance;

   // capacity register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mrq_pkg::CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   mrq_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mrq_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .item     (item),
      .advance  (advance),
      .result   (result)
   );

   mrq_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // level never exceeds the ring depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.level <= mrq_pkg::LVL_W'(mrq_pkg::DEPTH))
      else $error("level beyond ring depth");

   // a hand-over is always reported ok
   a_handover_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.handed_over) |-> rsp_data.status == mrq_pkg::ST_OK)
      else $error("hand-over with error status");

   // an empty get leaves nothing in the ring and returns no word
   a_empty_get: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == mrq_pkg::ST_EMPTY)
         |-> (rsp_data.level == '0 && rsp_data.msg_out == '0))
      else $error("empty status with data or level");

   // a word advances only into a free or draining result register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_data) && rsp_valid))
      else $error("result overwritten while stalled");
`endif

endmodule
